### sv/wwmf_pkg.sv
// ----------------------------------------------------------------------------
// Whole-word match finder package
// Shared constants, register indexes and result types.
// ----------------------------------------------------------------------------
package wwmf_pkg;

  localparam int MAX_WORD_DEF      = 16;
  localparam int POSITION_BITS_DEF = 20;

  localparam int FIELD_W = 20;
  localparam int WLEN_W  = 5;
  localparam int BYTE_W  = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_WORD_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_LOW   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_HIGH  = 2'd2;

  localparam logic [WLEN_W-1:0] WORD_LENGTH_RST = 5'd1;

  localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;

  localparam logic KIND_MATCH   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef struct packed {
    logic               result_kind;
    logic [FIELD_W-1:0] match_position;
    logic [FIELD_W-1:0] match_count;
    logic               last_of_run;
  } result_t;

  typedef struct packed {
    logic    first_valid;
    result_t first;
    logic    second_valid;
    result_t second;
  } result_pair_t;

endpackage

### sv/wwmf_in_if.sv
// ----------------------------------------------------------------------------
// Text byte channel
// Valid/ready channel carrying one text byte and its end-of-text mark.
// ----------------------------------------------------------------------------
interface wwmf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, text_byte, end_of_text, input ready);
  modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

### sv/wwmf_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one match or end-of-text summary result.
// ----------------------------------------------------------------------------
interface wwmf_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [19:0] match_position;
  logic [19:0] match_count;
  logic        last_of_run;

  modport source (output valid, result_kind, match_position, match_count, last_of_run,
                  input ready);
  modport sink   (input valid, result_kind, match_position, match_count, last_of_run,
                  output ready);
endinterface

### sv/wwmf_cfg_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the pattern length and bytes and presents the pattern as a byte array.
// ----------------------------------------------------------------------------
module wwmf_cfg_regs #(
  parameter int MAX_WORD = wwmf_pkg::MAX_WORD_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [wwmf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [wwmf_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output logic [wwmf_pkg::WLEN_W-1:0]      word_length_o,
  output logic [wwmf_pkg::BYTE_W-1:0]      pattern_o [MAX_WORD]
);
  import wwmf_pkg::*;

  logic [WLEN_W-1:0]     word_length_q;
  logic [CFG_DATA_W-1:0] chars_low_q;
  logic [CFG_DATA_W-1:0] chars_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_length_q <= WORD_LENGTH_RST;
      chars_low_q   <= '0;
      chars_high_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WORD_LENGTH: word_length_q <= cfg_wdata_i[WLEN_W-1:0];
        REG_CHARS_LOW:   chars_low_q   <= cfg_wdata_i;
        REG_CHARS_HIGH:  chars_high_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign word_length_o = word_length_q;

  for (genvar j = 0; j < MAX_WORD; j++) begin : g_pat
    if (j < 8) begin : g_low
      assign pattern_o[j] = chars_low_q[BYTE_W*j +: BYTE_W];
    end else if (j < 16) begin : g_high
      assign pattern_o[j] = chars_high_q[BYTE_W*(j-8) +: BYTE_W];
    end else begin : g_zero
      assign pattern_o[j] = '0;
    end
  end

endmodule

### sv/wwmf_scan.sv
// ----------------------------------------------------------------------------
// Scan stage
// Input register, byte history, position and count, and whole-word compare.
// ----------------------------------------------------------------------------
module wwmf_scan #(
  parameter int MAX_WORD      = wwmf_pkg::MAX_WORD_DEF,
  parameter int POSITION_BITS = wwmf_pkg::POSITION_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  wwmf_in_if.sink                      text_i,
  input  logic [wwmf_pkg::WLEN_W-1:0]  word_length_i,
  input  logic [wwmf_pkg::BYTE_W-1:0]  pattern_i [MAX_WORD],
  input  logic                         room_i,
  output wwmf_pkg::result_pair_t       pair_o
);
  import wwmf_pkg::*;

  localparam int CW = (POSITION_BITS > FIELD_W) ? POSITION_BITS : FIELD_W;
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam logic [CW-1:0] FIELD_MAX = CW'({FIELD_W{1'b1}});

  function automatic logic [FIELD_W-1:0] clamp(input logic [POSITION_BITS-1:0] v);
    logic [CW-1:0] w;
    w = CW'(v);
    if (w > FIELD_MAX) begin
      w = FIELD_MAX;
    end
    return w[FIELD_W-1:0];
  endfunction

  logic                     in_valid_q;
  logic [BYTE_W-1:0]        byte_q;
  logic                     last_q;
  logic [BYTE_W-1:0]        hist_q   [MAX_WORD+1];
  logic [BYTE_W-1:0]        hist_new [MAX_WORD+1];
  logic [BYTE_W-1:0]        hist_sel [MAX_WORD+1];
  logic [POSITION_BITS-1:0] pos_q;
  logic [POSITION_BITS-1:0] pos_d;
  logic [POSITION_BITS-1:0] cnt_q;
  logic [POSITION_BITS-1:0] cnt_d;
  logic [POSITION_BITS-1:0] avail;
  logic [POSITION_BITS-1:0] word_len_ext;
  logic [POSITION_BITS-1:0] start;
  logic                     accept;
  logic                     fire;
  logic                     is_space;
  logic                     hit;
  logic                     bytes_ok;
  logic                     delim_ok;
  logic                     k_ok;
  int                       k_int;
  result_t                  match_res;
  result_t                  summary_res;

  assign accept       = text_i.valid && text_i.ready;
  assign fire         = in_valid_q && room_i;
  assign text_i.ready = !in_valid_q || room_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept || (in_valid_q && !room_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= text_i.text_byte;
      last_q <= text_i.end_of_text;
    end
  end

  assign is_space     = (byte_q == SPACE_CHAR);
  assign pos_d        = (pos_q == POS_MAX) ? pos_q : pos_q + 1'b1;
  assign word_len_ext = POSITION_BITS'(word_length_i);
  assign k_int        = int'(word_length_i);
  assign avail        = is_space ? pos_q : pos_d;

  always_comb begin
    hist_new[0] = byte_q;
    for (int i = 1; i <= MAX_WORD; i++) begin
      hist_new[i] = hist_q[i-1];
    end
    for (int i = 0; i <= MAX_WORD; i++) begin
      hist_sel[i] = is_space ? hist_q[i] : hist_new[i];
    end
  end

  always_comb begin
    k_ok     = (word_length_i != '0) && (k_int <= MAX_WORD);
    bytes_ok = 1'b1;
    for (int i = 0; i < MAX_WORD; i++) begin
      for (int j = 0; j < MAX_WORD; j++) begin
        if (i + j + 1 == k_int) begin
          if (hist_sel[i] != pattern_i[j] || pattern_i[j] == SPACE_CHAR) begin
            bytes_ok = 1'b0;
          end
        end
      end
    end
    delim_ok = 1'b1;
    if (avail > word_len_ext) begin
      for (int i = 0; i <= MAX_WORD; i++) begin
        if (i == k_int && hist_sel[i] != SPACE_CHAR) begin
          delim_ok = 1'b0;
        end
      end
    end
    hit = (is_space || last_q) && k_ok && (avail >= word_len_ext) && bytes_ok && delim_ok;
  end

  assign cnt_d = (hit && cnt_q != POS_MAX) ? cnt_q + 1'b1 : cnt_q;
  assign start = (avail == POS_MAX) ? POS_MAX : avail - word_len_ext;

  always_comb begin
    match_res.result_kind    = KIND_MATCH;
    match_res.match_position = clamp(start);
    match_res.match_count    = clamp(cnt_d);
    match_res.last_of_run    = !last_q;

    summary_res.result_kind    = KIND_SUMMARY;
    summary_res.match_position = '0;
    summary_res.match_count    = clamp(cnt_d);
    summary_res.last_of_run    = 1'b1;

    pair_o.first_valid  = fire && (hit || last_q);
    pair_o.first        = hit ? match_res : summary_res;
    pair_o.second_valid = fire && hit && last_q;
    pair_o.second       = summary_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      cnt_q <= '0;
      for (int i = 0; i <= MAX_WORD; i++) begin
        hist_q[i] <= '0;
      end
    end else if (fire) begin
      if (last_q) begin
        pos_q <= '0;
        cnt_q <= '0;
        for (int i = 0; i <= MAX_WORD; i++) begin
          hist_q[i] <= '0;
        end
      end else begin
        pos_q  <= pos_d;
        cnt_q  <= cnt_d;
        hist_q <= hist_new;
      end
    end
  end

endmodule

### sv/wwmf_result_queue.sv
// ----------------------------------------------------------------------------
// Result queue
// Small register queue taking up to two results per cycle, one out per beat.
// ----------------------------------------------------------------------------
module wwmf_result_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  wwmf_pkg::result_pair_t pair_i,
  output logic                   room_o,
  wwmf_out_if.source             result_o
);
  import wwmf_pkg::*;

  result_t           entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] head_q;
  logic [QPTR_W-1:0] tail_q;
  logic [QCNT_W-1:0] count_q;
  logic [QCNT_W-1:0] push_n;
  logic              pop;
  result_t           head_entry;

  assign push_n = QCNT_W'(pair_i.first_valid) + QCNT_W'(pair_i.second_valid);
  assign pop    = result_o.valid && result_o.ready;
  assign room_o = (count_q <= QCNT_W'(QUEUE_DEPTH - 2));

  always_ff @(posedge clk_i) begin
    if (pair_i.first_valid) begin
      entry_q[tail_q] <= pair_i.first;
    end
    if (pair_i.second_valid) begin
      entry_q[tail_q + 1'b1] <= pair_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      tail_q  <= tail_q + push_n[QPTR_W-1:0];
      head_q  <= head_q + QPTR_W'(pop);
      count_q <= count_q + push_n - QCNT_W'(pop);
    end
  end

  assign head_entry              = entry_q[head_q];
  assign result_o.valid          = (count_q != '0);
  assign result_o.result_kind    = head_entry.result_kind;
  assign result_o.match_position = head_entry.match_position;
  assign result_o.match_count    = head_entry.match_count;
  assign result_o.last_of_run    = head_entry.last_of_run;

endmodule

### sv/whole_word_match_finder_top.sv
// ----------------------------------------------------------------------------
// Whole-word match finder
// Streams text bytes and reports each whole-word match of a set pattern.
// ----------------------------------------------------------------------------
// Usage:
//   text_i carries one text byte per beat with end_of_text on the final byte.
//   result_o carries match results (start offset, running count) and, after
//   the final byte, one summary result with the total count.
//   cfg_we_i/cfg_idx_i/cfg_wdata_i write word_length, word_chars_low and
//   word_chars_high; write them only while no text is in flight.
// Path: a byte's result is formed behind the input register and written into
//   the result queue, which offers it on result_o; a queue without room holds it.
// Throughput: one byte per cycle while the queue has room, set by the single
//   compare stage behind the input register; the result queue drains one beat
//   per cycle while result_o is ready; a final match byte queues both results.
// Stall: the four-entry result queue absorbs output stalls; text_i.ready
//   drops while a byte is held and fewer than two entries are free.
// Reset: history, position and count clear, word_length returns to 1 and the
//   pattern bytes to zero; the block takes bytes from the first cycle.
// ----------------------------------------------------------------------------
module whole_word_match_finder_top #(
  parameter int MAX_WORD      = wwmf_pkg::MAX_WORD_DEF,
  parameter int POSITION_BITS = wwmf_pkg::POSITION_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  wwmf_in_if.sink                         text_i,
  wwmf_out_if.source                      result_o,
  input  logic                            cfg_we_i,
  input  logic [wwmf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [wwmf_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import wwmf_pkg::*;

  logic [WLEN_W-1:0] word_length;
  logic [BYTE_W-1:0] pattern [MAX_WORD];
  logic              room;
  result_pair_t      pair;

  wwmf_cfg_regs #(
    .MAX_WORD (MAX_WORD)
  ) u_cfg_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .word_length_o (word_length),
    .pattern_o     (pattern)
  );

  wwmf_scan #(
    .MAX_WORD      (MAX_WORD),
    .POSITION_BITS (POSITION_BITS)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .text_i        (text_i),
    .word_length_i (word_length),
    .pattern_i     (pattern),
    .room_i        (room),
    .pair_o        (pair)
  );

  wwmf_result_queue u_result_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pair_i   (pair),
    .room_o   (room),
    .result_o (result_o)
  );

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Whole-word match finder testbench
// Streams directed and random texts through the block under several pattern
// settings and idling mixes. A local scanner predicts every match and summary
// beat, and the result monitor checks each beat in order, field by field.
// ----------------------------------------------------------------------------
module tb;
  import wwmf_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 10;
  localparam int PHASE_ITEMS    = 62;
  localparam logic [FIELD_W-1:0] POS_LIMIT = '1;

  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              end_of_text;
  } text_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  in_valid  = 1'b0;
  logic [BYTE_W-1:0]     in_byte   = '0;
  logic                  in_eot    = 1'b0;
  logic                  out_ready = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = REG_WORD_LENGTH;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  wwmf_in_if  text_if ();
  wwmf_out_if result_if ();

  assign text_if.valid       = in_valid;
  assign text_if.text_byte   = in_byte;
  assign text_if.end_of_text = in_eot;
  assign result_if.ready     = out_ready;

  whole_word_match_finder_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .text_i      (text_if),
    .result_o    (result_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #5 clk_i = ~clk_i;

  // Scanner state and pattern copy
  logic [WLEN_W-1:0]  pat_len = WORD_LENGTH_RST;
  logic [127:0]       pat_chars = '0;
  logic [BYTE_W-1:0]  history [0:MAX_WORD_DEF] = '{default: '0};
  logic [FIELD_W-1:0] text_pos = '0;
  logic [FIELD_W-1:0] hits = '0;

  result_t    expected_results [$];
  text_beat_t pending_beats [$];
  text_beat_t offer;
  logic [BYTE_W-1:0] text_buf [$];

  int unsigned mismatches    = 0;
  int unsigned random_items  = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned holds_asked   = 0;
  int unsigned holds_served  = 0;
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;

  function automatic logic [BYTE_W-1:0] pattern_at(int j);
    return pat_chars[8*j +: 8];
  endfunction

  function automatic bit word_closes(logic [FIELD_W-1:0] avail);
    int k;
    logic [BYTE_W-1:0] pb;
    k = int'(pat_len);
    if (k < 1 || k > MAX_WORD_DEF || avail < k) return 1'b0;
    for (int j = 0; j < k; j++) begin
      pb = pattern_at(j);
      if (pb == SPACE_CHAR || history[k-1-j] != pb) return 1'b0;
    end
    if (avail > k && history[k] != SPACE_CHAR) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void record_match(logic [FIELD_W-1:0] avail);
    result_t r;
    if (hits != POS_LIMIT) hits++;
    r.result_kind    = KIND_MATCH;
    r.match_position = (avail == POS_LIMIT) ? POS_LIMIT : avail - FIELD_W'(pat_len);
    r.match_count    = hits;
    r.last_of_run    = 1'b1;
    expected_results.push_back(r);
  endfunction

  function automatic void scan_text_byte(logic [BYTE_W-1:0] b, logic eot);
    bit matched;
    result_t r;
    matched = 1'b0;
    if (b == SPACE_CHAR && word_closes(text_pos)) begin
      record_match(text_pos);
      matched = 1'b1;
    end
    for (int i = MAX_WORD_DEF; i > 0; i--) history[i] = history[i-1];
    history[0] = b;
    if (text_pos != POS_LIMIT) text_pos++;
    if (eot) begin
      if (word_closes(text_pos)) begin
        record_match(text_pos);
        matched = 1'b1;
      end
      if (matched) expected_results[expected_results.size()-1].last_of_run = 1'b0;
      r.result_kind    = KIND_SUMMARY;
      r.match_position = '0;
      r.match_count    = hits;
      r.last_of_run    = 1'b1;
      expected_results.push_back(r);
      for (int i = 0; i <= MAX_WORD_DEF; i++) history[i] = '0;
      text_pos = '0;
      hits     = '0;
    end
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < 100) $display("tb: mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic compare_field(string name, logic [FIELD_W-1:0] got, logic [FIELD_W-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  task automatic check_result();
    result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("unexpected beat kind %0b count %0d",
                                result_if.result_kind, result_if.match_count));
      return;
    end
    want = expected_results.pop_front();
    compare_field("result_kind", FIELD_W'(result_if.result_kind), FIELD_W'(want.result_kind));
    compare_field("match_position", result_if.match_position, want.match_position);
    compare_field("match_count", result_if.match_count, want.match_count);
    compare_field("last_of_run", FIELD_W'(result_if.last_of_run), FIELD_W'(want.last_of_run));
  endtask

  // Text driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && text_if.ready) scan_text_byte(in_byte, in_eot);
      if (!in_valid || text_if.ready) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offer = pending_beats.pop_front();
          in_valid <= 1'b1;
          in_byte  <= offer.text_byte;
          in_eot   <= offer.end_of_text;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left    <= 0;
      holds_served <= 0;
    end else if (holds_served != holds_asked) begin
      hold_left    <= HOLD_CYCLES;
      holds_served <= holds_asked;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (result_if.valid && out_ready) check_result();
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && text_if.ready) || (result_if.valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_for_drain();
    while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_WORD_LENGTH: pat_len = data[WLEN_W-1:0];
      REG_CHARS_LOW:   pat_chars[63:0] = data;
      REG_CHARS_HIGH:  pat_chars[127:64] = data;
      default: ;
    endcase
  endtask

  task automatic set_pattern(logic [WLEN_W-1:0] len, logic [127:0] chars);
    logic [CFG_DATA_W-1:0] len_word;
    len_word = {$urandom(), $urandom()};
    len_word[WLEN_W-1:0] = len;
    write_reg(REG_WORD_LENGTH, len_word);
    write_reg(REG_CHARS_LOW, chars[63:0]);
    write_reg(REG_CHARS_HIGH, chars[127:64]);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [BYTE_W-1:0] nonspace_byte();
    logic [BYTE_W-1:0] b;
    b = BYTE_W'($urandom_range(255));
    return (b == SPACE_CHAR) ? 8'h21 : b;
  endfunction

  function automatic logic [63:0] pattern_word(bit few_symbols);
    logic [63:0] w;
    logic [BYTE_W-1:0] symbols [4] = '{8'h00, 8'hFF, 8'h61, 8'h62};
    for (int i = 0; i < 8; i++)
      w[8*i +: 8] = few_symbols ? symbols[$urandom_range(3)] : nonspace_byte();
    return w;
  endfunction

  task automatic add_word();
    int gen_len, kind, bad, stop;
    logic [BYTE_W-1:0] b;
    gen_len = (pat_len >= 1 && pat_len <= MAX_WORD_DEF) ? int'(pat_len)
                                                         : int'($urandom_range(1, MAX_WORD_DEF));
    kind = int'($urandom_range(99));
    if (kind >= 80) begin
      repeat ($urandom_range(1, 6)) text_buf.push_back(nonspace_byte());
      return;
    end
    bad  = (kind >= 65 && kind < 75) ? int'($urandom_range(gen_len - 1)) : -1;
    stop = (kind >= 75 && gen_len > 1) ? gen_len - 1 : gen_len;
    if (kind >= 45 && kind < 55) text_buf.push_back(nonspace_byte());
    for (int j = 0; j < stop; j++) begin
      b = (j == bad) ? nonspace_byte() : pattern_at(j);
      text_buf.push_back(b);
    end
    if (kind >= 55 && kind < 65) text_buf.push_back(nonspace_byte());
  endtask

  task automatic queue_text(bit pause_mid);
    for (int k = 0; k < text_buf.size(); k++) begin
      pending_beats.push_back('{text_byte: text_buf[k], end_of_text: k == text_buf.size() - 1});
      if (pause_mid && k == text_buf.size() / 2) wait_for_drain();
    end
  endtask

  task automatic add_text(bit pause_mid);
    int words;
    text_buf.delete();
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 30))
        text_buf.push_back(($urandom_range(3) == 0) ? SPACE_CHAR : BYTE_W'($urandom_range(255)));
    end else begin
      words = int'($urandom_range(1, 6));
      if ($urandom_range(4) == 0) text_buf.push_back(SPACE_CHAR);
      for (int k = 0; k < words; k++) begin
        if (k > 0) repeat ($urandom_range(1, 2)) text_buf.push_back(SPACE_CHAR);
        add_word();
      end
      if ($urandom_range(4) == 0) text_buf.push_back(SPACE_CHAR);
    end
    queue_text(pause_mid);
    random_items += text_buf.size();
  endtask

  initial begin
    int unsigned target;
    logic [WLEN_W-1:0] len;
    logic [127:0] chars;
    bit first_text;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset pattern: a single zero byte
    text_buf = '{8'h00};
    queue_text(1'b0);
    text_buf = '{SPACE_CHAR, 8'h00, SPACE_CHAR};
    queue_text(1'b0);
    text_buf = '{8'h00, 8'h00, SPACE_CHAR, 8'h00};
    queue_text(1'b0);
    text_buf = '{8'hFF, SPACE_CHAR, 8'h00, SPACE_CHAR, SPACE_CHAR, 8'h00};
    queue_text(1'b0);
    text_buf = '{8'h41};
    queue_text(1'b0);
    text_buf = '{SPACE_CHAR};
    queue_text(1'b0);
    wait_for_drain();

    for (int phase = 0; phase < 8; phase++) begin
      chars = {pattern_word(1'b0), pattern_word(1'b0)};
      case (phase)
        0: len = 5'd16;
        1: begin
          len = 5'd1;
          chars[7:0] = 8'hFF;
        end
        2: len = WLEN_W'($urandom_range(2, 15));
        3: len = 5'd0;
        4: len = WLEN_W'($urandom_range(17, 31));
        5: begin
          len = WLEN_W'($urandom_range(2, 8));
          chars[8*$urandom_range(len - 1) +: 8] = SPACE_CHAR;
        end
        6: begin
          len = WLEN_W'($urandom_range(1, 16));
          chars = {pattern_word(1'b1), pattern_word(1'b1)};
        end
        default: begin
          len = 5'd16;
          chars = {64'hFFFF_FFFF_FFFF_FFFF, 64'h0};
        end
      endcase
      set_pattern(len, chars);
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 88; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 88; end
        default: begin send_idle_pct = 22; stall_pct = 22; end
      endcase
      if (phase == 0) holds_asked++;
      target = random_items + PHASE_ITEMS;
      first_text = 1'b1;
      while (random_items < target) begin
        add_text(phase == 2 && first_text);
        first_text = 1'b0;
      end
      wait_for_drain();
    end

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
sv/wwmf_pkg.sv
sv/wwmf_in_if.sv
sv/wwmf_out_if.sv
sv/wwmf_cfg_regs.sv
sv/wwmf_scan.sv
sv/wwmf_result_queue.sv
sv/whole_word_match_finder_top.sv
bench/tb.sv
